// File: hw/rtl/cpp_pkg.sv
// Shared types and constants for the constrained point placement block.
package cpp_pkg;

    typedef enum logic [2:0] {
        ST_ACCEPT  = 3'd0,
        ST_CLOSE   = 3'd1,
        ST_FULL    = 3'd2,
        ST_OVER    = 3'd3,
        ST_EXHAUST = 3'd4,
        ST_READ    = 3'd5,
        ST_RANGE   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FINISH,
        S_RD_ISSUE,
        S_RD_DATA,
        S_DONE
    } state_t;

    localparam logic [2:0] CFG_TARGET_ATOMS  = 3'd0;
    localparam logic [2:0] CFG_ATTEMPT_LIMIT = 3'd1;
    localparam logic [2:0] CFG_MIN_DIST_SQ   = 3'd2;
    localparam logic [2:0] CFG_CUTOFF_SQ     = 3'd3;
    localparam logic [2:0] CFG_MAX_NEIGHBORS = 3'd4;

    localparam logic [10:0] RST_TARGET_ATOMS  = 11'd150;
    localparam logic [17:0] RST_ATTEMPT_LIMIT = 18'd200000;
    localparam logic [33:0] RST_MIN_DIST_SQ   = 34'd289014;
    localparam logic [33:0] RST_CUTOFF_SQ     = 34'd409600;
    localparam logic [2:0]  RST_MAX_NEIGHBORS = 3'd4;

    localparam int CFG_BITS = 34;

    typedef struct packed {
        status_t     status;
        logic [9:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [2:0]  nb;
        logic [10:0] placed;
    } result_t;

endpackage

// File: hw/rtl/cpp_ram.sv
// Generic single write port RAM with registered read.
module cpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cpp_dist.sv
// Chain of three stage cells: abs difference, square, sum of squares.
module cpp_dist #(
    parameter int COORD_BITS = 16,
    parameter int TAG_BITS   = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [TAG_BITS-1:0]       in_tag,
    input  logic [2:0]                in_nb,
    input  logic [3*COORD_BITS-1:0]   in_point,
    input  logic [3*COORD_BITS-1:0]   cand,
    output logic                      out_valid,
    output logic [TAG_BITS-1:0]       out_tag,
    output logic [2:0]                out_nb,
    output logic [2*COORD_BITS+1:0]   out_d2,
    output logic                      busy
);

    localparam int CB = COORD_BITS;
    localparam int SQ = 2 * COORD_BITS;

    logic              v1_reg, v2_reg, v3_reg;
    logic [TAG_BITS-1:0] t1_reg, t2_reg, t3_reg;
    logic [2:0]        n1_reg, n2_reg, n3_reg;
    logic [CB-1:0]     dif_reg [3];
    logic [CB-1:0]     dif_next [3];
    logic [SQ-1:0]     sq_reg [3];
    logic [SQ+1:0]     sum_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (cand[a*CB +: CB] > in_point[a*CB +: CB]) begin
                dif_next[a] = cand[a*CB +: CB] - in_point[a*CB +: CB];
            end else begin
                dif_next[a] = in_point[a*CB +: CB] - cand[a*CB +: CB];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        t1_reg <= in_tag;
        n1_reg <= in_nb;
        t2_reg <= t1_reg;
        n2_reg <= n1_reg;
        t3_reg <= t2_reg;
        n3_reg <= n2_reg;
        for (int a = 0; a < 3; a++) begin
            dif_reg[a] <= dif_next[a];
            sq_reg[a]  <= SQ'(dif_reg[a]) * SQ'(dif_reg[a]);
        end
        sum_reg <= (SQ+2)'(sq_reg[0]) + (SQ+2)'(sq_reg[1]) + (SQ+2)'(sq_reg[2]);
    end

    assign out_valid = v3_reg;
    assign out_tag   = t3_reg;
    assign out_nb    = n3_reg;
    assign out_d2    = sum_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

// File: hw/rtl/constrained_point_placement.sv
// Top level: point table, scan sequencer and distance cell chain.
//
//  channel | direction | handshake          | content
//  s_      | in        | s_tvalid/s_tready  | tuser op, tdata cand_x,y,z, read_index
//  m_      | out       | m_tvalid/m_tready  | tuser status, tdata slot..placed_count
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// A proposal makes one scan pass for the checks and one pass that raises
// neighbor counts, each one table read a cycle into the distance cell chain.
// A rejection stops the scan early.
// Reset is synchronous; the point table is not cleared and needs no pass.
// A stalled result holds in the output register while the next item is taken.
module constrained_point_placement #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // cand_x, cand_y, cand_z, read_index, zero pad
    input  logic [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // slot, out_x, out_y, out_z, neighbor_count, placed_count
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [33:0] cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int DW = 2 * COORD_BITS + 2;
    localparam int CW = (DW > cpp_pkg::CFG_BITS) ? DW : cpp_pkg::CFG_BITS;

    cpp_pkg::state_t  state_reg, state_next;
    cpp_pkg::result_t res_reg, res_next;

    logic [10:0]   target_reg;
    logic [17:0]   limit_reg;
    logic [33:0]   min_reg, cut_reg;
    logic [2:0]    maxn_reg;

    logic [PW-1:0] placed_reg, placed_next;
    logic [17:0]   attempt_reg, attempt_next;
    logic [3*CB-1:0] cand_reg, cand_next;
    logic [3:0]    own_reg, own_next;
    logic [PW-1:0] iss_reg, iss_next;
    logic [9:0]    idx_reg, idx_next;
    logic          rv_reg;
    logic [PW-1:0] rtag_reg;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [71:0]   m_tdata_reg, m_tdata_next;
    logic [2:0]    m_tuser_reg, m_tuser_next;

    logic          issue;
    logic [AW-1:0] raddr;
    logic          nb_we, co_we;
    logic [AW-1:0] nb_waddr;
    logic [2:0]    nb_wdata;
    logic [3*CB-1:0] co_rdata;
    logic [2:0]    nb_rdata;

    logic          d_valid, d_busy;
    logic [PW-1:0] d_tag;
    logic [2:0]    d_nb;
    logic [DW-1:0] d_d2;
    logic          too_close, in_cut, last;
    logic          exhausted;
    logic [3*CB-1:0] s_cand;

    assign s_cand = {CB'(s_tdata[47:32]), CB'(s_tdata[31:16]), CB'(s_tdata[15:0])};

    cpp_ram #(.WIDTH(3*CB), .DEPTH(MAX_POINTS)) u_coord_ram (
        .aclk  (aclk),
        .we    (co_we),
        .waddr (AW'(placed_reg)),
        .wdata (cand_reg),
        .raddr (raddr),
        .rdata (co_rdata)
    );

    cpp_ram #(.WIDTH(3), .DEPTH(MAX_POINTS)) u_nb_ram (
        .aclk  (aclk),
        .we    (nb_we),
        .waddr (nb_waddr),
        .wdata (nb_wdata),
        .raddr (raddr),
        .rdata (nb_rdata)
    );

    cpp_dist #(.COORD_BITS(CB), .TAG_BITS(PW)) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rv_reg),
        .in_tag    (rtag_reg),
        .in_nb     (nb_rdata),
        .in_point  (co_rdata),
        .cand      (cand_reg),
        .out_valid (d_valid),
        .out_tag   (d_tag),
        .out_nb    (d_nb),
        .out_d2    (d_d2),
        .busy      (d_busy)
    );

    assign too_close = CW'(d_d2) < CW'(min_reg);
    assign in_cut    = CW'(d_d2) <= CW'(cut_reg);
    assign last      = d_tag == (placed_reg - PW'(1));
    assign exhausted = (32'(placed_reg) >= 32'(target_reg)) ||
                       (32'(placed_reg) >= MAX_POINTS) ||
                       (attempt_reg >= limit_reg);

    assign raddr     = (state_reg == cpp_pkg::S_RD_ISSUE) ? AW'(idx_reg) : AW'(iss_reg);
    assign s_tready  = (state_reg == cpp_pkg::S_IDLE) && !rv_reg && !d_busy;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cpp_pkg::S_IDLE;
            placed_reg   <= '0;
            attempt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            rv_reg       <= 1'b0;
            target_reg   <= cpp_pkg::RST_TARGET_ATOMS;
            limit_reg    <= cpp_pkg::RST_ATTEMPT_LIMIT;
            min_reg      <= cpp_pkg::RST_MIN_DIST_SQ;
            cut_reg      <= cpp_pkg::RST_CUTOFF_SQ;
            maxn_reg     <= cpp_pkg::RST_MAX_NEIGHBORS;
        end else begin
            state_reg    <= state_next;
            placed_reg   <= placed_next;
            attempt_reg  <= attempt_next;
            m_tvalid_reg <= m_tvalid_next;
            rv_reg       <= issue;
            if (cfg_valid) begin
                unique case (cfg_index)
                    cpp_pkg::CFG_TARGET_ATOMS:  target_reg <= cfg_data[10:0];
                    cpp_pkg::CFG_ATTEMPT_LIMIT: limit_reg  <= cfg_data[17:0];
                    cpp_pkg::CFG_MIN_DIST_SQ:   min_reg    <= cfg_data;
                    cpp_pkg::CFG_CUTOFF_SQ:     cut_reg    <= cfg_data;
                    cpp_pkg::CFG_MAX_NEIGHBORS: maxn_reg   <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
        res_reg     <= res_next;
        cand_reg    <= cand_next;
        own_reg     <= own_next;
        iss_reg     <= iss_next;
        idx_reg     <= idx_next;
        rtag_reg    <= iss_reg;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        placed_next   = placed_reg;
        attempt_next  = attempt_reg;
        cand_next     = cand_reg;
        own_next      = own_reg;
        iss_next      = iss_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        issue         = 1'b0;
        nb_we         = 1'b0;
        co_we         = 1'b0;
        nb_waddr      = AW'(d_tag);
        nb_wdata      = d_nb + 3'd1;

        unique case (state_reg)
            cpp_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser[0]) begin
                        idx_next   = s_tdata[57:48];
                        state_next = cpp_pkg::S_RD_ISSUE;
                    end else if (exhausted) begin
                        res_next        = '0;
                        res_next.status = cpp_pkg::ST_EXHAUST;
                        res_next.placed = 11'(placed_reg);
                        state_next      = cpp_pkg::S_DONE;
                    end else begin
                        attempt_next = attempt_reg + 18'd1;
                        cand_next    = s_cand;
                        own_next     = '0;
                        iss_next     = '0;
                        state_next   = (placed_reg == '0) ? cpp_pkg::S_FINISH
                                                          : cpp_pkg::S_SCAN;
                    end
                end
            end
            cpp_pkg::S_SCAN: begin
                if (iss_reg < placed_reg) begin
                    issue    = 1'b1;
                    iss_next = iss_reg + PW'(1);
                end
                if (d_valid) begin
                    res_next        = '0;
                    res_next.placed = 11'(placed_reg);
                    // first failing point decides; later items in flight are dropped
                    priority if (too_close) begin
                        res_next.status = cpp_pkg::ST_CLOSE;
                        state_next      = cpp_pkg::S_DONE;
                    end else if (in_cut && (d_nb >= maxn_reg)) begin
                        res_next.status = cpp_pkg::ST_FULL;
                        state_next      = cpp_pkg::S_DONE;
                    end else if (in_cut && ((own_reg + 4'd1) > {1'b0, maxn_reg})) begin
                        res_next.status = cpp_pkg::ST_OVER;
                        state_next      = cpp_pkg::S_DONE;
                    end else begin
                        if (in_cut) begin
                            own_next = own_reg + 4'd1;
                        end
                        if (last) begin
                            iss_next   = '0;
                            state_next = cpp_pkg::S_UPDATE;
                        end
                    end
                end
            end
            cpp_pkg::S_UPDATE: begin
                if (iss_reg < placed_reg) begin
                    issue    = 1'b1;
                    iss_next = iss_reg + PW'(1);
                end
                if (d_valid) begin
                    nb_we = in_cut;
                    if (last) begin
                        state_next = cpp_pkg::S_FINISH;
                    end
                end
            end
            cpp_pkg::S_FINISH: begin
                co_we           = 1'b1;
                nb_we           = 1'b1;
                nb_waddr        = AW'(placed_reg);
                nb_wdata        = 3'(own_reg);
                placed_next     = placed_reg + PW'(1);
                res_next.status = cpp_pkg::ST_ACCEPT;
                res_next.slot   = 10'(placed_reg);
                res_next.x      = 16'(cand_reg[0 +: CB]);
                res_next.y      = 16'(cand_reg[CB +: CB]);
                res_next.z      = 16'(cand_reg[2*CB +: CB]);
                res_next.nb     = 3'(own_reg);
                res_next.placed = 11'(placed_reg + PW'(1));
                state_next      = cpp_pkg::S_DONE;
            end
            cpp_pkg::S_RD_ISSUE: begin
                state_next = cpp_pkg::S_RD_DATA;
            end
            cpp_pkg::S_RD_DATA: begin
                res_next        = '0;
                res_next.slot   = idx_reg;
                res_next.placed = 11'(placed_reg);
                if ((32'(idx_reg) < 32'(placed_reg)) && (32'(idx_reg) < MAX_POINTS)) begin
                    res_next.status = cpp_pkg::ST_READ;
                    res_next.x      = 16'(co_rdata[0 +: CB]);
                    res_next.y      = 16'(co_rdata[CB +: CB]);
                    res_next.z      = 16'(co_rdata[2*CB +: CB]);
                    res_next.nb     = nb_rdata;
                end else begin
                    res_next.status = cpp_pkg::ST_RANGE;
                end
                state_next = cpp_pkg::S_DONE;
            end
            cpp_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_reg.status;
                    m_tdata_next  = {res_reg.placed, res_reg.nb, res_reg.z,
                                     res_reg.y, res_reg.x, res_reg.slot};
                    state_next    = cpp_pkg::S_IDLE;
                end
            end
            default: state_next = cpp_pkg::S_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/cpp_checker.sv
// Port-level checks for the constrained point placement block, with bind.
module cpp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [33:0] cfg_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_accept_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == cpp_pkg::ST_ACCEPT) |-> m_tdata[71:61] != 11'd0)
        else $error("accepted point with zero placed count");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == cpp_pkg::ST_EXHAUST || m_tuser == cpp_pkg::ST_CLOSE ||
                     m_tuser == cpp_pkg::ST_FULL || m_tuser == cpp_pkg::ST_OVER)
        |-> m_tdata[60:0] == 61'd0)
        else $error("refused proposal carries point data");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is at work");

endmodule

bind constrained_point_placement cpp_checker u_cpp_checker (.*);

// File: tb/tb.sv
// Testbench for constrained_point_placement: directed and random proposals and reads, scoreboard check.
`timescale 1ns / 1ps

class placement_board;
    logic [15:0] tx[1024], ty[1024], tz[1024];
    logic [2:0]  tnb[1024];
    int unsigned placed, attempts;
    logic [10:0] target;
    logic [17:0] att_lim;
    logic [33:0] min_sq, cut_sq;
    logic [2:0]  max_nb;
    cpp_pkg::result_t pending[$];
    int errors;

    function new();
        placed = 0; attempts = 0; errors = 0;
        target = cpp_pkg::RST_TARGET_ATOMS;
        att_lim = cpp_pkg::RST_ATTEMPT_LIMIT;
        min_sq = cpp_pkg::RST_MIN_DIST_SQ;
        cut_sq = cpp_pkg::RST_CUTOFF_SQ;
        max_nb = cpp_pkg::RST_MAX_NEIGHBORS;
    endfunction

    function void set_reg(logic [2:0] idx, logic [33:0] val);
        case (idx)
            cpp_pkg::CFG_TARGET_ATOMS:  target = val[10:0];
            cpp_pkg::CFG_ATTEMPT_LIMIT: att_lim = val[17:0];
            cpp_pkg::CFG_MIN_DIST_SQ:   min_sq = val;
            cpp_pkg::CFG_CUTOFF_SQ:     cut_sq = val;
            cpp_pkg::CFG_MAX_NEIGHBORS: max_nb = val[2:0];
            default: ;
        endcase
    endfunction

    function longint unsigned dsq(int i, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        longint unsigned dx, dy, dz;
        dx = (x > tx[i]) ? x - tx[i] : tx[i] - x;
        dy = (y > ty[i]) ? y - ty[i] : ty[i] - y;
        dz = (z > tz[i]) ? z - tz[i] : tz[i] - z;
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_item(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [9:0] ridx);
        cpp_pkg::result_t r;
        longint unsigned d;
        int own;
        r = '0;
        if (op) begin
            r.slot = ridx;
            if (ridx < placed) begin
                r.status = cpp_pkg::ST_READ;
                r.x = tx[ridx]; r.y = ty[ridx]; r.z = tz[ridx]; r.nb = tnb[ridx];
            end else begin
                r.status = cpp_pkg::ST_RANGE;
            end
        end else if (placed >= target || placed >= 1024 || attempts >= att_lim) begin
            r.status = cpp_pkg::ST_EXHAUST;
        end else begin
            attempts++;
            own = 0;
            r.status = cpp_pkg::ST_ACCEPT;
            for (int i = 0; i < placed; i++) begin
                d = dsq(i, x, y, z);
                if (d < min_sq) begin
                    r.status = cpp_pkg::ST_CLOSE; break;
                end
                if (d <= cut_sq) begin
                    if (tnb[i] + 1 > max_nb) begin
                        r.status = cpp_pkg::ST_FULL; break;
                    end
                    own++;
                    if (own > max_nb) begin
                        r.status = cpp_pkg::ST_OVER; break;
                    end
                end
            end
            if (r.status == cpp_pkg::ST_ACCEPT) begin
                for (int i = 0; i < placed; i++)
                    if (dsq(i, x, y, z) <= cut_sq) tnb[i] = tnb[i] + 3'd1;
                tx[placed] = x; ty[placed] = y; tz[placed] = z; tnb[placed] = own[2:0];
                r.slot = placed[9:0]; r.x = x; r.y = y; r.z = z; r.nb = own[2:0];
                placed++;
            end
        end
        r.placed = placed[10:0];
        pending.push_back(r);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_result(logic [2:0] st, logic [71:0] d);
        cpp_pkg::result_t e;
        if (pending.size() == 0) begin
            report("unexpected item", st, 0);
            return;
        end
        e = pending.pop_front();
        if (st !== e.status) report("status", st, e.status);
        if (d[9:0] !== e.slot) report("slot", d[9:0], e.slot);
        if (d[25:10] !== e.x) report("out_x", d[25:10], e.x);
        if (d[41:26] !== e.y) report("out_y", d[41:26], e.y);
        if (d[57:42] !== e.z) report("out_z", d[57:42], e.z);
        if (d[60:58] !== e.nb) report("neighbor_count", d[60:58], e.nb);
        if (d[71:61] !== e.placed) report("placed_count", d[71:61], e.placed);
    endtask
endclass

module tb;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [33:0] cfg_data = '0;

    placement_board board = new();
    bit quiet = 0;
    int sent = 0;

    constrained_point_placement dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #400ms;
        $display("simulation failed");
        $finish;
    end

    // Result side: random stall bursts until the quiet tail.
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 13);
                m_tready <= 0;
                repeat (gap) begin
                    @(posedge aclk);
                end
                m_tready <= 1;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [33:0] val);
        @(posedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        board.set_reg(idx, val);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic send(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                        logic [9:0] ridx);
        int gap;
        // the block is busy after an accept
        gap = 1;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
        end
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {6'd0, ridx, z, y, x};
        do @(posedge aclk); while (!s_tready);
        board.note_item(op, x, y, z, ridx);
        sent++;
        s_tvalid <= 0;
    endtask

    // Proposal near a placed point (or anywhere at random), so close/full/over cases occur.
    task automatic near_propose();
        int k;
        logic [15:0] x, y, z;
        if (board.placed == 0 || $urandom_range(0, 3) == 0) begin
            send(0, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
        end else begin
            k = $urandom_range(0, board.placed - 1);
            x = 16'(board.tx[k] + $urandom_range(0, 1200) - 600);
            y = 16'(board.ty[k] + $urandom_range(0, 1200) - 600);
            z = 16'(board.tz[k] + $urandom_range(0, 1200) - 600);
            send(0, x, y, z, 10'($urandom));
        end
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                send(1, 16'($urandom), 16'($urandom), 16'($urandom),
                     10'((board.placed > 0 && $urandom_range(0, 3) != 0) ?
                         $urandom_range(0, board.placed - 1) : $urandom));
            else
                near_propose();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, reads of empty table, crowding one spot.
        send(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0);
        send(1, 16'h0000, 16'h0000, 16'h0000, 10'h3FF);
        send(0, 16'h0000, 16'h0000, 16'h0000, 10'h3FF);
        send(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0);
        send(0, 16'h0000, 16'h0000, 16'h0000, 10'd0);
        send(0, 16'h0300, 16'h0000, 16'h0000, 10'd0);
        send(0, 16'h0000, 16'h0240, 16'h0000, 10'd0);
        send(0, 16'h0000, 16'h0000, 16'h0240, 10'd0);
        send(0, 16'h0180, 16'h0180, 16'h0000, 10'd0);
        send(0, 16'h0180, 16'h0000, 16'h0180, 10'd0);
        send(1, 16'd0, 16'd0, 16'd0, 10'd0);
        send(1, 16'd0, 16'd0, 16'd0, 10'd1);
        send(1, 16'd0, 16'd0, 16'd0, 10'd2);
        drain();

        // Zero neighbor limit, wide cutoff.
        write_reg(cpp_pkg::CFG_MAX_NEIGHBORS, 34'd0);
        write_reg(cpp_pkg::CFG_CUTOFF_SQ, 34'h3FFFFFFFF);
        send(0, 16'h8000, 16'h8000, 16'h8000, 10'd0);
        drain();
        write_reg(cpp_pkg::CFG_MAX_NEIGHBORS, 34'd7);
        write_reg(cpp_pkg::CFG_MIN_DIST_SQ, 34'd0);
        for (int i = 0; i < 9; i++)
            send(0, 16'(16'h4000 + i), 16'h4000, 16'h4000, 10'd0);
        drain();

        // Exhaustion by target and by attempt limit, then set new working values.
        write_reg(cpp_pkg::CFG_TARGET_ATOMS, 34'd0);
        send(0, 16'd1, 16'd2, 16'd3, 10'd0);
        drain();
        write_reg(cpp_pkg::CFG_TARGET_ATOMS, 34'd1024);
        write_reg(cpp_pkg::CFG_ATTEMPT_LIMIT, 34'd0);
        send(0, 16'd1, 16'd2, 16'd3, 10'd0);
        drain();
        write_reg(cpp_pkg::CFG_ATTEMPT_LIMIT, 34'h3FFFF);
        write_reg(cpp_pkg::CFG_MIN_DIST_SQ, 34'd200000);
        write_reg(cpp_pkg::CFG_CUTOFF_SQ, 34'd409600);
        write_reg(cpp_pkg::CFG_MAX_NEIGHBORS, 34'd4);

        random_phase(100);
        drain();
        write_reg(cpp_pkg::CFG_MIN_DIST_SQ, 34'd50000);
        write_reg(cpp_pkg::CFG_CUTOFF_SQ, 34'd600000);
        write_reg(cpp_pkg::CFG_MAX_NEIGHBORS, 34'd2);
        random_phase(100);
        drain();
        write_reg(cpp_pkg::CFG_ATTEMPT_LIMIT, 34'(board.attempts + 30));
        write_reg(cpp_pkg::CFG_MAX_NEIGHBORS, 34'd7);
        quiet = 1;
        random_phase(50);

        drain();
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
